@@ design/mmhpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhpq_pkg: shared types and constants for the min/max heap priority queue
// Request and result layouts, operation codes, ordering modes and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package mmhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int          VAL_W        = 32;
  localparam int          KIND_W       = 3;
  localparam int          STATUS_W     = 2;
  localparam int          COUNT_W      = 6;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAX     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MIN     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_MAX   = 2'd1,
    MODE_MIN   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count_after;
  } out_item_t;

  // Datapath actions, one per controller step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_UP_CHK,
    OP_UP_CMP,
    OP_EX_ROOT,
    OP_EX_LAST,
    OP_DN_CHK,
    OP_DN_L,
    OP_DN_R,
    OP_DN_DEC,
    OP_RB_NEXT,
    OP_RB_LD,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              up_stop;
    logic              up_move;
    logic              dn_leaf;
    logic              has_r;
    logic              dn_move;
    logic              rb_end;
    logic              out_free;
  } dp_status_t;

  // True when a must sit above b in the given mode.
  function automatic logic ranks_above(mode_t m, logic signed [VAL_W-1:0] a,
                                       logic signed [VAL_W-1:0] b);
    logic r;
    case (m)
      MODE_MAX: r = (a > b);
      MODE_MIN: r = (a < b);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ design/mmhpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhpq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/mmhpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhpq_ctrl: sequencing state machine for the heap queue
// Steps the datapath through add, extract, sift and rebuild sequences.
// ----------------------------------------------------------------------------
module mmhpq_ctrl import mmhpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_UP_CHK  = 12'b0000_0000_0010,
    S_UP_CMP  = 12'b0000_0000_0100,
    S_EX_ROOT = 12'b0000_0000_1000,
    S_EX_LAST = 12'b0000_0001_0000,
    S_DN_CHK  = 12'b0000_0010_0000,
    S_DN_L    = 12'b0000_0100_0000,
    S_DN_R    = 12'b0000_1000_0000,
    S_DN_DEC  = 12'b0001_0000_0000,
    S_RB_NEXT = 12'b0010_0000_0000,
    S_RB_LD   = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   rebuild_r, rebuild_nxt;
  state_t sift_exit;

  assign in_ready  = (state_r == S_IDLE);
  // A finished sift-down either resumes the rebuild sweep or ends the request.
  assign sift_exit = rebuild_r ? S_RB_NEXT : S_DONE;

  always_comb begin
    state_nxt   = state_r;
    rebuild_nxt = rebuild_r;
    cmd.op      = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = OP_ACCEPT;
          rebuild_nxt = 1'b0;
          case (st.kind)
            KIND_ADD:     state_nxt = st.full ? S_DONE : S_UP_CHK;
            KIND_EXTRACT: state_nxt = st.empty ? S_DONE : S_EX_ROOT;
            KIND_MAX, KIND_MIN: begin
              rebuild_nxt = 1'b1;
              state_nxt   = S_RB_NEXT;
            end
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_UP_CHK: begin
        cmd.op    = OP_UP_CHK;
        state_nxt = st.up_stop ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op    = OP_UP_CMP;
        state_nxt = st.up_move ? S_UP_CHK : S_DONE;
      end
      S_EX_ROOT: begin
        cmd.op    = OP_EX_ROOT;
        state_nxt = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd.op    = OP_EX_LAST;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        cmd.op    = OP_DN_CHK;
        state_nxt = st.dn_leaf ? sift_exit : S_DN_L;
      end
      S_DN_L: begin
        cmd.op    = OP_DN_L;
        state_nxt = st.has_r ? S_DN_R : S_DN_DEC;
      end
      S_DN_R: begin
        cmd.op    = OP_DN_R;
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        cmd.op    = OP_DN_DEC;
        state_nxt = st.dn_move ? S_DN_CHK : sift_exit;
      end
      S_RB_NEXT: begin
        cmd.op    = OP_RB_NEXT;
        state_nxt = st.rb_end ? S_DONE : S_RB_LD;
      end
      S_RB_LD: begin
        cmd.op    = OP_RB_LD;
        state_nxt = S_DN_CHK;
      end
      S_DONE: begin
        cmd.op = OP_DONE;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rebuild_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rebuild_r <= rebuild_nxt;
    end
  end

endmodule

@@ design/mmhpq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhpq_dp: heap datapath
// Element store, count, mode, the moving hole index and value, the
// comparators for sifting and the result register.
// ----------------------------------------------------------------------------
module mmhpq_dp import mmhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 1;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [CW-1:0]           k_r, k_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic signed [VAL_W-1:0] x_r, x_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic signed [VAL_W-1:0] b_r, b_nxt;
  logic                    lb_r, lb_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  logic [STATUS_W-1:0]     stat_r, stat_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [VAL_W-1:0]        wr_data, rd_raw;
  logic signed [VAL_W-1:0] rd_data;

  logic [IW-1:0]           child_l;
  logic [IW:0]             child_r;
  logic [AW-1:0]           idx_m1, parent;
  logic [CW-1:0]           cnt_m1, k_m1;
  logic signed [VAL_W-1:0] best_v;
  logic                    lb_now, rb;

  mmhpq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign rd_data = rd_raw;

  // Tree navigation around the hole index.
  assign child_l = {idx_r, 1'b1};
  assign child_r = (IW + 1)'({idx_r, 1'b0}) + (IW + 1)'(2);
  assign idx_m1  = idx_r - AW'(1);
  assign parent  = idx_m1 >> 1;
  assign cnt_m1  = cnt_r - CW'(1);
  assign k_m1    = k_r - CW'(1);

  assign lb_now = ranks_above(mode_r, rd_data, x_r);
  assign best_v = lb_r ? a_r : x_r;
  assign rb     = st.has_r && ranks_above(mode_r, b_r, best_v);

  always_comb begin
    st.kind     = in_data.kind;
    st.full     = (cnt_r >= CW'(CAPACITY));
    st.empty    = (cnt_r == '0);
    st.up_stop  = (idx_r == '0) || (mode_r == MODE_PLAIN);
    st.up_move  = ranks_above(mode_r, x_r, rd_data);
    st.dn_leaf  = (child_l >= IW'(cnt_r)) || (mode_r == MODE_PLAIN);
    st.has_r    = (child_r < (IW + 1)'(cnt_r));
    st.dn_move  = lb_r || rb;
    st.rb_end   = (k_r == '0);
    st.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    lb_nxt        = lb_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = x_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (cmd.op)
      OP_ACCEPT: begin
        res_nxt  = '0;
        stat_nxt = ST_OK;
        case (in_data.kind)
          KIND_ADD: begin
            if (st.full) begin
              stat_nxt = ST_FULL;
            end else begin
              x_nxt   = in_data.value;
              idx_nxt = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          KIND_EXTRACT: begin
            if (st.empty) begin
              stat_nxt = ST_EMPTY;
            end
            rd_en = 1'b1;
          end
          KIND_PLAIN: mode_nxt = MODE_PLAIN;
          KIND_MAX: begin
            mode_nxt = MODE_MAX;
            k_nxt    = cnt_r >> 1;
          end
          KIND_MIN: begin
            mode_nxt = MODE_MIN;
            k_nxt    = cnt_r >> 1;
          end
          default: ;
        endcase
      end
      OP_UP_CHK: begin
        if (st.up_stop) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      OP_UP_CMP: begin
        // The parent moves down into the hole, or the new value settles here.
        wr_en = 1'b1;
        if (st.up_move) begin
          wr_data = rd_data;
          idx_nxt = parent;
        end
      end
      OP_EX_ROOT: begin
        res_nxt = rd_data;
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
      end
      OP_EX_LAST: begin
        x_nxt   = rd_data;
        cnt_nxt = cnt_m1;
        idx_nxt = '0;
      end
      OP_DN_CHK: begin
        if (st.dn_leaf) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_l[AW-1:0];
        end
      end
      OP_DN_L: begin
        a_nxt  = rd_data;
        lb_nxt = lb_now;
        if (st.has_r) begin
          rd_en   = 1'b1;
          rd_addr = child_r[AW-1:0];
        end
      end
      OP_DN_R: b_nxt = rd_data;
      OP_DN_DEC: begin
        wr_en = 1'b1;
        if (st.dn_move) begin
          wr_data = rb ? b_r : a_r;
          idx_nxt = rb ? child_r[AW-1:0] : child_l[AW-1:0];
        end
      end
      OP_RB_NEXT: begin
        if (!st.rb_end) begin
          rd_en   = 1'b1;
          rd_addr = k_m1[AW-1:0];
          idx_nxt = k_m1[AW-1:0];
          k_nxt   = k_m1;
        end
      end
      OP_RB_LD: x_nxt = rd_data;
      OP_DONE: begin
        if (st.out_free) begin
          out_nxt.result_value = res_r;
          out_nxt.status       = stat_r;
          out_nxt.count_after  = COUNT_W'(cnt_r);
          out_valid_nxt        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mode_r      <= MODE_PLAIN;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    x_r    <= x_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    lb_r   <= lb_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1)) ||
             (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("element count moved by more than one");

  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_ACCEPT) |=> $stable(mode_r))
    else $error("ordering mode changed outside request acceptance");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.result_value == '0))
    else $error("dropped request carries a nonzero result value");
`endif

endmodule

@@ design/min_max_heap_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_heap_priority_queue: bounded array heap with plain, max and min modes
// Accepts add, extract and mode/rebuild requests and returns one result each.
//
//   Channel  Ports                      Carries
//   in       in_valid/in_ready/in_data  request: kind, value
//   out      out_valid/out_ready/out_data  result: result_value, status,
//                                          count_after
//
// Add sifts the new element up one tree level at a time, stopping at the root,
// in plain mode or when a compare stops it; an element moves at most
// clog2(CAPACITY) levels. Extract reads the root and the last element and then
// sifts down; each level costs registered reads of the element memory plus a
// compare. A rebuild sifts down each of the count/2 internal nodes in turn.
// Reset is synchronous and clears the count and mode; the element memory needs
// no clearing. A result that waits in the output register does not block the
// next request, which stalls only at its final step until the output register
// is free.
// ----------------------------------------------------------------------------
module min_max_heap_priority_queue import mmhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  mmhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  mmhpq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the min/max heap priority queue
// Sends add, extract, plain-mode and rebuild requests through the valid/ready
// request channel. A behavioral heap inside the testbench predicts every
// result, and each returned result is compared field by field against it.
// Both channels idle at random. One phase holds off the result channel for a
// long stretch, and the last phase runs without idling.
// ----------------------------------------------------------------------------
module tb_top;
  import mmhpq_pkg::*;

  localparam int unsigned     HEAP_DEPTH   = CAPACITY_DEF;
  localparam logic [KIND_W-1:0] KIND_LAST  = 3'd7;
  localparam int              HOLD_CYCLES  = 300;
  localparam int              TAIL_CYCLES  = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Behavioral copy of the heap, advanced at each accepted request.
  logic signed [VAL_W-1:0] heap_slots [HEAP_DEPTH];
  int unsigned             heap_count = 0;
  mode_t                   heap_mode = MODE_PLAIN;

  out_item_t pending_results [$];
  int        mismatch_count = 0;
  bit        hold_off_req = 1'b0;
  bit        quiet_phase = 1'b0;

  min_max_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit outranks(logic signed [VAL_W-1:0] a,
                                  logic signed [VAL_W-1:0] b);
    bit r;
    r = 1'b0;
    if (heap_mode == MODE_MAX) r = (a > b);
    else if (heap_mode == MODE_MIN) r = (a < b);
    return r;
  endfunction

  function automatic void swap_slots(int unsigned i, int unsigned j);
    logic signed [VAL_W-1:0] t;
    t = heap_slots[i];
    heap_slots[i] = heap_slots[j];
    heap_slots[j] = t;
  endfunction

  function automatic void sink_from(int unsigned start);
    int unsigned i, l, r, best;
    i = start;
    while (i < heap_count) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      // Ties keep the parent; equal children favor the left one.
      if (l < heap_count && outranks(heap_slots[l], heap_slots[best])) best = l;
      if (r < heap_count && outranks(heap_slots[r], heap_slots[best])) best = r;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic void float_from(int unsigned start);
    int unsigned i, p;
    i = start;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(heap_slots[i], heap_slots[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void reorder_heap(mode_t m);
    heap_mode = m;
    for (int i = heap_count / 2; i > 0; i--) sink_from(i - 1);
  endfunction

  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.kind)
      KIND_ADD: begin
        if (heap_count >= HEAP_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          heap_slots[heap_count] = req.value;
          heap_count++;
          float_from(heap_count - 1);
        end
      end
      KIND_EXTRACT: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // In plain mode the last element just lands on the root.
          res.result_value = heap_slots[0];
          heap_slots[0] = heap_slots[heap_count - 1];
          heap_count--;
          sink_from(0);
        end
      end
      KIND_PLAIN: heap_mode = MODE_PLAIN;
      KIND_MAX:   reorder_heap(MODE_MAX);
      KIND_MIN:   reorder_heap(MODE_MIN);
      default:    ;
    endcase
    res.count_after = COUNT_W'(heap_count);
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result returned with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch($sformatf("result_value got %0d expected %0d",
                                    out_data.result_value, want.result_value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_data.status, want.status));
        if (out_data.count_after !== want.count_after)
          report_mismatch($sformatf("count_after got %0d expected %0d",
                                    out_data.count_after, want.count_after));
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin : result_ready_driver
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Valid stays high from one request to the next unless a gap is taken.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [VAL_W-1:0] value);
    in_item_t req;
    int gap;
    req.kind = kind;
    req.value = value;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VAL_W-1){1'b0}}};
          1: v = {1'b0, {(VAL_W-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      // A narrow range makes ties common.
      1, 2, 3: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_directed_cases();
    send_request(KIND_EXTRACT, 0);                          // extract when empty
    send_request(KIND_ADD, {1'b1, {(VAL_W-1){1'b0}}});
    send_request(KIND_ADD, {1'b0, {(VAL_W-1){1'b1}}});
    send_request(KIND_ADD, 0);
    send_request(KIND_ADD, -1);
    send_request(KIND_EXTRACT, 32'h5A5A_A5A5);              // plain: no sifting
    for (int k = KIND_MIN + 1; k <= KIND_LAST; k++) send_request(KIND_W'(k), $urandom);
    send_request(KIND_MAX, 0);
    send_request(KIND_ADD, 7);
    send_request(KIND_ADD, 7);
    send_request(KIND_ADD, 7);
    send_request(KIND_EXTRACT, 0);
    send_request(KIND_EXTRACT, 0);
    send_request(KIND_MIN, 0);
    send_request(KIND_ADD, -7);
    send_request(KIND_EXTRACT, 0);
    send_request(KIND_PLAIN, 0);
    send_request(KIND_ADD, 3);
    send_request(KIND_EXTRACT, 0);
    wait_for_results();
  endtask

  // Fills past capacity and then drains past empty in the given heap mode.
  task automatic test_fill_and_drain(input logic [KIND_W-1:0] mode_kind);
    send_request(mode_kind, 0);
    for (int i = 0; i <= HEAP_DEPTH; i++) send_request(KIND_ADD, pick_value());
    for (int i = 0; i <= HEAP_DEPTH; i++) send_request(KIND_EXTRACT, pick_value());
  endtask

  task automatic test_result_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_request(($urandom_range(0, 2) == 0) ? KIND_EXTRACT : KIND_ADD, pick_value());
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int n_items);
    int add_pct, roll;
    logic [KIND_W-1:0] kind;
    add_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      // Segments that grow, shrink or hover keep reaching full and empty.
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 72;
          1: add_pct = 25;
          default: add_pct = 48;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < add_pct) kind = KIND_ADD;
      else if (roll < 90) kind = KIND_EXTRACT;
      else if (roll < 93) kind = KIND_MAX;
      else if (roll < 96) kind = KIND_MIN;
      else if (roll < 98) kind = KIND_PLAIN;
      else kind = KIND_W'($urandom_range(KIND_MIN + 1, KIND_LAST));
      send_request(kind, pick_value());
      if ($urandom_range(0, 299) == 0) wait_for_results();
    end
  endtask

  task automatic test_quiet_tail(input int n_items);
    quiet_phase = 1'b1;
    test_random_traffic(n_items);
  endtask

  initial begin : main_sequence
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_fill_and_drain(KIND_MAX);
    test_fill_and_drain(KIND_MIN);
    test_result_backpressure();
    test_random_traffic(1200);
    test_quiet_tail(160);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
design/mmhpq_pkg.sv
design/mmhpq_ram.sv
design/mmhpq_ctrl.sv
design/mmhpq_dp.sv
design/min_max_heap_priority_queue.sv
verif/tb_top.sv
